[design/dcrf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// DMA register file package
// Shared widths, function codes, port codes and the controller command bundle.
// ----------------------------------------------------------------------------
package dcrf_pkg;

    localparam int FUNC_W    = 3;
    localparam int PORT_W    = 5;
    localparam int BYTE_W    = 8;
    localparam int CHAN_W    = 3;
    localparam int ADDR_W    = 24;
    localparam int LEN_W     = 17;

    localparam int REG_BYTES  = 32;
    localparam int TOGGLES    = 16;
    localparam int PAGE_BYTES = 16;

    // Function codes of one bus access.
    localparam logic [FUNC_W-1:0] FUNC_CTL_READ   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_CTL_WRITE  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_PAGE_READ  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_PAGE_WRITE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_QUERY      = 3'd4;

    // Controller port codes after the second controller's halving.
    localparam logic [PORT_W-1:0] PORT_COMMAND      = 5'd8;
    localparam logic [PORT_W-1:0] PORT_MASK_BIT     = 5'd10;
    localparam logic [PORT_W-1:0] PORT_MODE         = 5'd11;
    localparam logic [PORT_W-1:0] PORT_TOGGLE_RESET = 5'd12;
    localparam logic [PORT_W-1:0] PORT_MASTER_CLEAR = 5'd13;
    localparam logic [PORT_W-1:0] PORT_SIXTEEN      = 5'd16;

    localparam logic [CHAN_W-1:0] QUERY_CHANNEL  = 3'd2;
    localparam logic [BYTE_W-1:0] CMD_READ_VALUE = 8'h04;
    localparam logic [BYTE_W-1:0] BYTE_ALL_ONES  = 8'hFF;

    typedef struct packed {
        logic load;   // capture the accepted transfer
        logic exec;   // perform the access and register the result
    } dcrf_cmd_t;

endpackage
`default_nettype wire

[design/dma_controller_register_file.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// DMA controller register file
// Two cascaded DMA controllers with byte-toggled registers and page registers.
// ----------------------------------------------------------------------------
// Usage:
// A transfer is taken at a rising edge where start is high and busy is low;
// func, controller, port, value and channel are sampled at that edge.
// Each transfer yields exactly one result: done is high for one cycle and
// read_data, error, dest_address and byte_length are valid in that cycle.
// done rises after the execute cycle, in which the result registers are
// loaded, and the result is taken at the edge that ends the done cycle. busy
// is high only in the execute cycle, so a new transfer may be started during
// the result cycle, while the previous result is shown; this pace is set by
// the single execute step of the controller state machine.
// The receiver cannot stall; a result not taken in its cycle is gone.
// Reset clears all register bytes, byte toggles and page registers to zero
// and returns the controller to idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dma_controller_register_file (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [dcrf_pkg::FUNC_W-1:0]     func,
    input  wire logic                            controller,
    input  wire logic [dcrf_pkg::PORT_W-1:0]     port,
    input  wire logic [dcrf_pkg::BYTE_W-1:0]     value,
    input  wire logic [dcrf_pkg::CHAN_W-1:0]     channel,
    output logic                                 done,
    output logic      [dcrf_pkg::BYTE_W-1:0]     read_data,
    output logic                                 error,
    output logic      [dcrf_pkg::ADDR_W-1:0]     dest_address,
    output logic      [dcrf_pkg::LEN_W-1:0]      byte_length
);
    import dcrf_pkg::*;

    dcrf_cmd_t cmd;

    dcrf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    dcrf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .func         (func),
        .controller   (controller),
        .port         (port),
        .value        (value),
        .channel      (channel),
        .read_data    (read_data),
        .error        (error),
        .dest_address (dest_address),
        .byte_length  (byte_length)
    );

    // An accepted transfer always enters the execute cycle next.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transfer did not enter execute");

    // The execute cycle is always followed by exactly one result strobe.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("execute cycle not followed by a result");

    // A result strobe only follows an execute cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without execute");

    // A page read always reports all ones with an error.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(func, 2) == FUNC_PAGE_READ && $past(start && !busy, 2)
        |-> error && read_data == BYTE_ALL_ONES)
        else $error("page read result wrong");

endmodule
`default_nettype wire

[design/dcrf_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// DMA register file controller
// Sequences each transfer through capture, execute and result strobe.
// ----------------------------------------------------------------------------
module dcrf_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output dcrf_pkg::dcrf_cmd_t    cmd,
    output logic                   busy,
    output logic                   done
);
    import dcrf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign busy   = (state_reg == ST_EXEC);
    assign done   = (state_reg == ST_RESP);
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            ST_IDLE, ST_RESP:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_RESP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

[design/dcrf_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// DMA register file datapath
// Register bytes, byte toggles, page registers and the result registers.
// ----------------------------------------------------------------------------
module dcrf_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire dcrf_pkg::dcrf_cmd_t             cmd,
    input  wire logic [dcrf_pkg::FUNC_W-1:0]     func,
    input  wire logic                            controller,
    input  wire logic [dcrf_pkg::PORT_W-1:0]     port,
    input  wire logic [dcrf_pkg::BYTE_W-1:0]     value,
    input  wire logic [dcrf_pkg::CHAN_W-1:0]     channel,
    output logic      [dcrf_pkg::BYTE_W-1:0]     read_data,
    output logic                                 error,
    output logic      [dcrf_pkg::ADDR_W-1:0]     dest_address,
    output logic      [dcrf_pkg::LEN_W-1:0]      byte_length
);
    import dcrf_pkg::*;

    // Captured transfer.
    logic [FUNC_W-1:0] func_reg;
    logic              ctl_reg;
    logic [PORT_W-1:0] port_reg;
    logic [BYTE_W-1:0] value_reg;
    logic [CHAN_W-1:0] channel_reg;

    // Architectural state.
    logic [BYTE_W-1:0] reg_bytes_reg  [REG_BYTES];
    logic [BYTE_W-1:0] reg_bytes_next [REG_BYTES];
    logic              toggles_reg    [TOGGLES];
    logic              toggles_next   [TOGGLES];
    logic [BYTE_W-1:0] page_reg       [PAGE_BYTES];
    logic [BYTE_W-1:0] page_next      [PAGE_BYTES];

    // Result registers.
    logic [BYTE_W-1:0] read_data_reg, read_data_next;
    logic              error_reg, error_next;
    logic [ADDR_W-1:0] dest_reg, dest_next;
    logic [LEN_W-1:0]  len_reg, len_next;

    logic [PORT_W-1:0] eff_port;
    logic [3:0]        tog_idx;
    logic [4:0]        slot;
    logic              reg_port;

    // The second controller's port is halved, so each of its registers sits on a pair of ports.
    assign eff_port = ctl_reg ? {1'b0, port_reg[PORT_W-1:1]} : port_reg;
    assign reg_port = (eff_port[PORT_W-1:3] == 2'b00);
    assign tog_idx  = {ctl_reg, eff_port[2:0]};
    assign slot     = {ctl_reg, eff_port[2:0], toggles_reg[tog_idx]};

    always_comb
    begin
        reg_bytes_next = reg_bytes_reg;
        toggles_next   = toggles_reg;
        page_next      = page_reg;
        read_data_next = '0;
        error_next     = 1'b0;
        dest_next      = '0;
        len_next       = '0;

        case (func_reg)
            FUNC_CTL_READ:
            begin
                if (reg_port)
                begin
                    read_data_next        = reg_bytes_reg[slot];
                    toggles_next[tog_idx] = !toggles_reg[tog_idx];
                end
                else if (eff_port == PORT_COMMAND)
                begin
                    read_data_next = CMD_READ_VALUE;
                end
                else if (eff_port != PORT_SIXTEEN)
                begin
                    error_next = 1'b1;
                end
            end
            FUNC_CTL_WRITE:
            begin
                if (reg_port)
                begin
                    reg_bytes_next[slot]  = value_reg;
                    toggles_next[tog_idx] = !toggles_reg[tog_idx];
                end
                else if (eff_port == PORT_MASTER_CLEAR)
                begin
                    for (int i = 0; i < 16; i++)
                    begin
                        reg_bytes_next[{ctl_reg, 4'(i)}] = '0;
                    end
                    for (int i = 0; i < 8; i++)
                    begin
                        toggles_next[{ctl_reg, 3'(i)}] = 1'b0;
                    end
                end
                else if (eff_port == PORT_MODE || eff_port == PORT_MASK_BIT)
                begin
                    // Accepted and dropped: mode and mask are not kept.
                end
                else if (eff_port == PORT_TOGGLE_RESET)
                begin
                    if (value_reg != '0)
                    begin
                        error_next = (value_reg != BYTE_ALL_ONES);
                        for (int i = 0; i < 8; i++)
                        begin
                            toggles_next[{ctl_reg, 3'(i)}] = 1'b0;
                        end
                    end
                end
                else
                begin
                    error_next = 1'b1;
                end
            end
            FUNC_PAGE_READ:
            begin
                read_data_next = BYTE_ALL_ONES;
                error_next     = 1'b1;
            end
            FUNC_PAGE_WRITE:
            begin
                if (!port_reg[PORT_W-1])
                begin
                    page_next[port_reg[3:0]] = value_reg;
                end
                else
                begin
                    error_next = 1'b1;
                end
            end
            FUNC_QUERY:
            begin
                if (channel_reg == QUERY_CHANNEL)
                begin
                    // Channel 2 address is register 4, its count register 5.
                    dest_next = {page_reg[1], reg_bytes_reg[9], reg_bytes_reg[8]};
                    len_next  = {1'b0, reg_bytes_reg[11], reg_bytes_reg[10]} + 17'd1;
                end
                else
                begin
                    error_next = 1'b1;
                end
            end
            default:
            begin
                error_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg    <= func;
            ctl_reg     <= controller;
            port_reg    <= port;
            value_reg   <= value;
            channel_reg <= channel;
        end
        if (cmd.exec)
        begin
            read_data_reg <= read_data_next;
            error_reg     <= error_next;
            dest_reg      <= dest_next;
            len_reg       <= len_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_BYTES; i++)
            begin
                reg_bytes_reg[i] <= '0;
            end
            for (int i = 0; i < TOGGLES; i++)
            begin
                toggles_reg[i] <= 1'b0;
            end
            for (int i = 0; i < PAGE_BYTES; i++)
            begin
                page_reg[i] <= '0;
            end
        end
        else if (cmd.exec)
        begin
            reg_bytes_reg <= reg_bytes_next;
            toggles_reg   <= toggles_next;
            page_reg      <= page_next;
        end
    end

    assign read_data    = read_data_reg;
    assign error        = error_reg;
    assign dest_address = dest_reg;
    assign byte_length  = len_reg;

endmodule
`default_nettype wire

[tb/tb_dma_controller_register_file.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMA controller register file testbench
// Sends controller, page and query transfers in random bursts, predicts each
// result from a local copy of the register bytes, toggles and page registers,
// and checks every done strobe field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_dma_controller_register_file;

    import dcrf_pkg::*;

    localparam int          ITEM_TARGET   = 650;
    localparam int          IDLE_LIMIT    = 2000;
    localparam int          SETTLE_CYCLES = 6;
    localparam logic [PORT_W-1:0] LAST_PAIR_REG = 5'd7;
    localparam logic [PORT_W-1:0] REG_CH2_ADDR  = 5'd4;
    localparam logic [PORT_W-1:0] REG_CH2_COUNT = 5'd5;
    localparam logic [PORT_W-1:0] PAGE_CH2      = 5'd1;
    localparam logic [PORT_W-1:0] PAGE_LIMIT    = 5'd16;
    localparam logic [FUNC_W-1:0] FUNC_RESERVED = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_LAST     = 3'd7;
    localparam logic [CHAN_W-1:0] CHAN_LAST     = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              controller;
        logic [PORT_W-1:0] port;
        logic [BYTE_W-1:0] value;
        logic [CHAN_W-1:0] channel;
        logic              wait_idle;
    } bus_access_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              error;
        logic [ADDR_W-1:0] dest_address;
        logic [LEN_W-1:0]  byte_length;
    } access_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [FUNC_W-1:0] func = '0;
    logic              controller = 1'b0;
    logic [PORT_W-1:0] port = '0;
    logic [BYTE_W-1:0] value = '0;
    logic [CHAN_W-1:0] channel = '0;
    logic              busy;
    logic              done;
    logic [BYTE_W-1:0] read_data;
    logic              error;
    logic [ADDR_W-1:0] dest_address;
    logic [LEN_W-1:0]  byte_length;

    dma_controller_register_file DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .controller   (controller),
        .port         (port),
        .value        (value),
        .channel      (channel),
        .done         (done),
        .read_data    (read_data),
        .error        (error),
        .dest_address (dest_address),
        .byte_length  (byte_length)
    );

    always #5 clk = ~clk;

    bus_access_t    access_queue[$];
    access_result_t results_due[$];

    logic [BYTE_W-1:0] reg_byte_copy [REG_BYTES];
    logic              toggle_copy   [TOGGLES];
    logic [BYTE_W-1:0] page_copy     [PAGE_BYTES];

    int mismatch_count = 0;
    int accepted_count = 0;
    int query_count = 0;
    int error_count = 0;
    int checked_count = 0;
    int idle_cycles = 0;
    int burst_left = 1;
    int gap_left = 0;

    initial
    begin
        foreach (reg_byte_copy[i]) reg_byte_copy[i] = '0;
        foreach (toggle_copy[i]) toggle_copy[i] = 1'b0;
        foreach (page_copy[i]) page_copy[i] = '0;
    end

    // Returns the byte slot of a two-byte register and flips its toggle.
    function automatic logic [4:0] take_byte_slot(input logic ctl, input logic [2:0] r);
        logic [3:0] t;
        logic [4:0] slot;
        t = {ctl, r};
        slot = {ctl, r, toggle_copy[t]};
        toggle_copy[t] = ~toggle_copy[t];
        return slot;
    endfunction

    function automatic access_result_t predict_access(input bus_access_t a);
        access_result_t r;
        logic [PORT_W-1:0] p;
        r = '0;
        p = a.controller ? (a.port >> 1) : a.port;
        case (a.func)
            FUNC_CTL_READ:
                if (p <= LAST_PAIR_REG)
                    r.read_data = reg_byte_copy[take_byte_slot(a.controller, p[2:0])];
                else if (p == PORT_COMMAND)
                    r.read_data = CMD_READ_VALUE;
                else if (p != PORT_SIXTEEN)
                    r.error = 1'b1;
            FUNC_CTL_WRITE:
                if (p <= LAST_PAIR_REG)
                    reg_byte_copy[take_byte_slot(a.controller, p[2:0])] = a.value;
                else if (p == PORT_MASTER_CLEAR)
                begin
                    for (int i = 0; i < 16; i++) reg_byte_copy[{a.controller, 4'(i)}] = '0;
                    for (int i = 0; i < 8; i++) toggle_copy[{a.controller, 3'(i)}] = 1'b0;
                end
                else if (p == PORT_TOGGLE_RESET)
                begin
                    if (a.value != '0)
                    begin
                        r.error = (a.value != BYTE_ALL_ONES);
                        for (int i = 0; i < 8; i++) toggle_copy[{a.controller, 3'(i)}] = 1'b0;
                    end
                end
                else if (p != PORT_MODE && p != PORT_MASK_BIT)
                    r.error = 1'b1;
            FUNC_PAGE_READ:
            begin
                r.read_data = BYTE_ALL_ONES;
                r.error = 1'b1;
            end
            FUNC_PAGE_WRITE:
                if (a.port < PAGE_LIMIT)
                    page_copy[a.port[3:0]] = a.value;
                else
                    r.error = 1'b1;
            FUNC_QUERY:
                if (a.channel == QUERY_CHANNEL)
                begin
                    r.dest_address = {page_copy[PAGE_CH2],
                                      reg_byte_copy[{REG_CH2_ADDR[3:0], 1'b1}],
                                      reg_byte_copy[{REG_CH2_ADDR[3:0], 1'b0}]};
                    r.byte_length = {1'b0, reg_byte_copy[{REG_CH2_COUNT[3:0], 1'b1}],
                                     reg_byte_copy[{REG_CH2_COUNT[3:0], 1'b0}]} + 17'd1;
                end
                else
                    r.error = 1'b1;
            default:
                r.error = 1'b1;
        endcase
        return r;
    endfunction

    task automatic add_access(input logic [FUNC_W-1:0] f, input logic ctl,
                              input logic [PORT_W-1:0] prt, input logic [BYTE_W-1:0] val,
                              input logic [CHAN_W-1:0] ch, input logic hold);
        bus_access_t a;
        a = '{func: f, controller: ctl, port: prt, value: val, channel: ch, wait_idle: hold};
        access_queue.push_back(a);
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Driver: a transfer is accepted at an edge where start is high and busy is low.
    always @(posedge clk)
    begin : driver
        bus_access_t    next_acc;
        access_result_t want;
        logic           taken;
        if (rst_n)
        begin
            taken = start && !busy;
            if (taken)
            begin
                next_acc = '{func: func, controller: controller, port: port,
                             value: value, channel: channel, wait_idle: 1'b0};
                want = predict_access(next_acc);
                results_due.push_back(want);
                accepted_count++;
                if (func == FUNC_QUERY) query_count++;
                if (want.error) error_count++;
            end
            if (!(start && !taken))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start <= 1'b0;
                end
                else if (access_queue.size() == 0 ||
                         (access_queue[0].wait_idle && results_due.size() != 0))
                    start <= 1'b0;
                else
                begin
                    next_acc = access_queue.pop_front();
                    func <= next_acc.func;
                    controller <= next_acc.controller;
                    port <= next_acc.port;
                    value <= next_acc.value;
                    channel <= next_acc.channel;
                    start <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                                  : $urandom_range(1, 10);
                        gap_left <= $urandom_range(0, 7);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Monitor: results cannot be held off, so every done strobe is checked.
    always @(posedge clk)
    begin : monitor
        access_result_t want;
        if (rst_n && done)
        begin
            if (results_due.size() == 0)
                report_mismatch("result strobe with no transfer outstanding");
            else
            begin
                want = results_due.pop_front();
                checked_count++;
                if (read_data !== want.read_data)
                    report_mismatch($sformatf("read_data %0h, expected %0h",
                                              read_data, want.read_data));
                if (error !== want.error)
                    report_mismatch($sformatf("error %0b, expected %0b", error, want.error));
                if (dest_address !== want.dest_address)
                    report_mismatch($sformatf("dest_address %0h, expected %0h",
                                              dest_address, want.dest_address));
                if (byte_length !== want.byte_length)
                    report_mismatch($sformatf("byte_length %0h, expected %0h",
                                              byte_length, want.byte_length));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transfer or result for %0d cycles", IDLE_LIMIT);
                $display("tb_dma_controller_register_file: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        logic ctl;
        int   pick;

        // Program channel 2 for the largest count and read it back.
        add_access(FUNC_CTL_READ, 1'b0, 5'd0, 8'h00, 3'd0, 1'b0);
        add_access(FUNC_CTL_WRITE, 1'b0, REG_CH2_ADDR, 8'h34, 3'd0, 1'b0);
        add_access(FUNC_CTL_WRITE, 1'b0, REG_CH2_ADDR, 8'h12, 3'd0, 1'b0);
        add_access(FUNC_CTL_WRITE, 1'b0, REG_CH2_COUNT, 8'hFF, 3'd0, 1'b0);
        add_access(FUNC_CTL_WRITE, 1'b0, REG_CH2_COUNT, 8'hFF, 3'd0, 1'b0);
        add_access(FUNC_PAGE_WRITE, 1'b0, PAGE_CH2, 8'hFF, 3'd0, 1'b0);
        add_access(FUNC_QUERY, 1'b0, 5'd0, 8'h00, QUERY_CHANNEL, 1'b0);
        add_access(FUNC_QUERY, 1'b1, 5'd31, 8'hFF, CHAN_LAST, 1'b0);
        add_access(FUNC_CTL_READ, 1'b0, PORT_COMMAND, 8'h00, 3'd0, 1'b0);
        add_access(FUNC_CTL_READ, 1'b0, PORT_SIXTEEN, 8'h00, 3'd0, 1'b0);
        add_access(FUNC_CTL_READ, 1'b1, 5'd31, 8'h00, 3'd0, 1'b0);
        add_access(FUNC_CTL_WRITE, 1'b0, PORT_MODE, 8'hFF, 3'd0, 1'b0);
        add_access(FUNC_CTL_WRITE, 1'b0, PORT_MASK_BIT, 8'h5A, 3'd0, 1'b0);
        // Leave the address toggle on the high byte, then try each reset value.
        add_access(FUNC_CTL_WRITE, 1'b0, REG_CH2_ADDR, 8'hA5, 3'd0, 1'b0);
        add_access(FUNC_CTL_WRITE, 1'b0, PORT_TOGGLE_RESET, 8'h00, 3'd0, 1'b0);
        add_access(FUNC_CTL_WRITE, 1'b0, PORT_TOGGLE_RESET, 8'h55, 3'd0, 1'b0);
        add_access(FUNC_CTL_WRITE, 1'b0, REG_CH2_ADDR, 8'h00, 3'd0, 1'b0);
        add_access(FUNC_CTL_WRITE, 1'b0, PORT_TOGGLE_RESET, BYTE_ALL_ONES, 3'd0, 1'b0);
        // Second controller: register 4 sits on ports 8 and 9, master clear on 26 and 27.
        add_access(FUNC_CTL_WRITE, 1'b1, 5'd8, 8'hFF, 3'd0, 1'b0);
        add_access(FUNC_CTL_READ, 1'b1, 5'd9, 8'h00, 3'd0, 1'b0);
        add_access(FUNC_CTL_WRITE, 1'b1, 5'd27, 8'h00, 3'd0, 1'b0);
        add_access(FUNC_CTL_WRITE, 1'b0, PORT_MASTER_CLEAR, 8'h00, 3'd0, 1'b1);
        add_access(FUNC_QUERY, 1'b0, 5'd31, 8'hFF, QUERY_CHANNEL, 1'b0);
        add_access(FUNC_PAGE_READ, 1'b0, 5'd3, 8'h00, 3'd0, 1'b0);
        add_access(FUNC_PAGE_WRITE, 1'b1, 5'd31, 8'hFF, 3'd0, 1'b0);
        add_access(FUNC_RESERVED, 1'b1, 5'd31, 8'hFF, CHAN_LAST, 1'b0);
        add_access(FUNC_LAST, 1'b0, 5'd0, 8'h00, 3'd0, 1'b1);

        while (access_queue.size() < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                // Mostly well-formed channel 2 programming with random content.
                if ($urandom_range(0, 3) != 0)
                    add_access(FUNC_CTL_WRITE, 1'b0, PORT_TOGGLE_RESET, BYTE_ALL_ONES,
                               3'($urandom), $urandom_range(0, 40) == 0);
                repeat (2) add_access(FUNC_CTL_WRITE, 1'b0, REG_CH2_ADDR, 8'($urandom),
                                      3'($urandom), 1'b0);
                repeat (2) add_access(FUNC_CTL_WRITE, 1'b0, REG_CH2_COUNT, 8'($urandom),
                                      3'($urandom), 1'b0);
                add_access(FUNC_PAGE_WRITE, 1'($urandom), PAGE_CH2, 8'($urandom),
                           3'($urandom), 1'b0);
                if ($urandom_range(0, 1))
                    add_access(FUNC_PAGE_WRITE, 1'($urandom), 5'($urandom_range(0, 15)),
                               8'($urandom), 3'($urandom), 1'b0);
                add_access(FUNC_QUERY, 1'($urandom), 5'($urandom), 8'($urandom),
                           QUERY_CHANNEL, 1'b0);
                if ($urandom_range(0, 2) == 0)
                    repeat (2) add_access(FUNC_CTL_READ, 1'b0,
                                          5'($urandom_range(REG_CH2_ADDR, REG_CH2_COUNT)),
                                          8'($urandom), 3'($urandom), 1'b0);
            end
            else if (pick < 8)
            begin
                // Register traffic on either controller, pairs included.
                ctl = 1'($urandom);
                repeat ($urandom_range(1, 4))
                    add_access(3'($urandom_range(FUNC_CTL_READ, FUNC_CTL_WRITE)), ctl,
                               5'($urandom_range(0, ctl ? 31 : 17)), 8'($urandom),
                               3'($urandom), 1'b0);
            end
            else
                add_access(3'($urandom), 1'($urandom), 5'($urandom), 8'($urandom),
                           3'($urandom), $urandom_range(0, 60) == 0);
        end

        repeat (7) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (access_queue.size() != 0 || results_due.size() != 0 || start)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("summary: %0d transfers accepted, %0d results checked", accepted_count,
                 checked_count);
        $display("summary: %0d channel queries, %0d error results, %0d mismatches",
                 query_count, error_count, mismatch_count);
        if (mismatch_count == 0)
            $display("tb_dma_controller_register_file: done, clean");
        else
            $display("tb_dma_controller_register_file: done, errors");
        $finish;
    end

endmodule
